[design/planar_odometry_integrator_macros.svh]
// Assertion macros for the planar odometry integrator.
// Included by the checker; no other dependencies.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH

// Checked property, switched off while reset is high.
`define POI_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define POI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/poi_pkg.sv]
// Shared constants, types and tables of the planar odometry integrator.
// No dependencies.
package poi_pkg;

  localparam int ACC_W  = 66;  // serial MAC accumulator
  localparam int TRIG_W = 34;  // CORDIC vector, Q2.30 with headroom
  localparam int DIV_W  = 52;  // divider dividend magnitude
  localparam int SUM_W  = 54;  // position sum before saturation

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ANG_K      = 32'd87496355;
  localparam int          ANG_K_BITS = 27;
  localparam logic [9:0]  DIV_K      = 10'd1000;
  localparam logic [ACC_W-1:0] DIV_HALF = 66'd500;
  localparam logic [ACC_W-1:0] ROT_HALF = 66'd536870912;  // 2^29
  localparam int          ROT_SHIFT  = 30;

  localparam logic signed [SUM_W-1:0] SAT_HI = 54'sh7FFFFFFF;
  localparam logic signed [SUM_W-1:0] SAT_LO = -(54'sh80000000);
  localparam logic signed [19:0] QUAT_HI = 20'sd65536;
  localparam logic signed [19:0] QUAT_LO = -20'sd65536;

  typedef struct packed {
    logic       start;
    logic       sub;    // subtract the product
    logic       sgn;    // multiplier is two's complement
    logic [5:0] nbits;  // multiplier bits to walk
  } mac_cmd_t;

  // arctan(2^-i) as a binary angle, 2^32 = 2*pi
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[design/poi_if.sv]
// Valid/ready channel interfaces for the odometry integrator.
// Depends on nothing.
interface poi_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        step_ms;
  logic signed [31:0] vel_fwd;
  logic signed [31:0] vel_side;
  logic signed [31:0] yaw_rate;
  modport source(output valid, step_ms, vel_fwd, vel_side, yaw_rate, input ready);
  modport sink(input valid, step_ms, vel_fwd, vel_side, yaw_rate, output ready);
endinterface

interface poi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading_angle;
  logic signed [17:0] quat_z;
  logic signed [17:0] quat_w;
  modport source(output valid, pos_x, pos_y, heading_angle, quat_z, quat_w, input ready);
  modport sink(input valid, pos_x, pos_y, heading_angle, quat_z, quat_w, output ready);
endinterface

[design/poi_cordic.sv]
// Iterative rotation-mode CORDIC: cos and sin in Q2.30 of a 2*pi binary angle.
// Depends on poi_pkg.
module poi_cordic #(
  parameter int STEPS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [31:0]                     angle,
  output logic                            done,
  output logic signed [poi_pkg::TRIG_W-1:0] cos_o,
  output logic signed [poi_pkg::TRIG_W-1:0] sin_o
);
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                            busy;
  logic [CNT_W-1:0]                cnt;
  logic                            flip;
  logic signed [poi_pkg::TRIG_W-1:0] x, y, z;
  logic [31:0]                     ang_f;
  logic                            fold;
  logic signed [poi_pkg::TRIG_W-1:0] atn;

  // second and third quadrant: rotate by pi first
  assign fold  = angle[31] ^ angle[30];
  assign ang_f = fold ? (angle ^ 32'h80000000) : angle;
  assign atn   = {2'b00, poi_pkg::atan_entry(5'(cnt))};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      flip <= fold;
      x    <= poi_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= {{2{ang_f[31]}}, ang_f};
    end else if (busy) begin
      if (!z[poi_pkg::TRIG_W-1]) begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - atn;
      end else begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + atn;
      end
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign cos_o = flip ? -x : x;
  assign sin_o = flip ? -y : y;
endmodule

[design/poi_mac.sv]
// Bit-serial multiply-accumulate: one multiplier bit per cycle.
// Depends on poi_pkg.
module poi_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  poi_pkg::mac_cmd_t              cmd,
  input  logic signed [poi_pkg::ACC_W-1:0] a,
  input  logic [31:0]                    b,
  input  logic [poi_pkg::ACC_W-1:0]      init,
  output logic                           done,
  output logic signed [poi_pkg::ACC_W-1:0] acc
);
  logic                           busy;
  logic [5:0]                     cnt;
  logic                           sub, sgn;
  logic signed [poi_pkg::ACC_W-1:0] mcand;
  logic [31:0]                    mplier;
  logic                           neg;

  // top bit of a signed multiplier carries negative weight
  assign neg = sub ^ (sgn && cnt == 6'd0);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy   <= 1'b1;
      cnt    <= cmd.nbits - 6'd1;
      sub    <= cmd.sub;
      sgn    <= cmd.sgn;
      acc    <= init;
      mcand  <= a;
      mplier <= b;
    end else if (busy) begin
      if (mplier[0])
        acc <= neg ? acc - mcand : acc + mcand;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      if (cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end
endmodule

[design/poi_div1000.sv]
// Restoring divider by 1000, one quotient bit per cycle, floor rounding.
// Depends on poi_pkg.
module poi_div1000 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [poi_pkg::ACC_W-1:0] t,
  output logic                           done,
  output logic signed [poi_pkg::DIV_W:0] q
);
  localparam int CNT_W = $clog2(poi_pkg::DIV_W);

  logic                       busy, neg;
  logic [CNT_W-1:0]           cnt;
  logic [poi_pkg::DIV_W-1:0]  u, quo;
  logic [9:0]                 rem;
  logic [10:0]                trial;
  logic [poi_pkg::ACC_W-1:0]  t_neg;

  // floor of a negative value: -ceil(-t/1000) = -((-t + 999) / 1000)
  assign t_neg = -t + poi_pkg::ACC_W'(poi_pkg::DIV_K - 10'd1);
  assign trial = {rem, u[poi_pkg::DIV_W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      neg  <= t[poi_pkg::ACC_W-1];
      u    <= t[poi_pkg::ACC_W-1] ? t_neg[poi_pkg::DIV_W-1:0] : t[poi_pkg::DIV_W-1:0];
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, poi_pkg::DIV_K}) begin
        rem <= 10'(trial - {1'b0, poi_pkg::DIV_K});
        quo <= {quo[poi_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[9:0];
        quo <= {quo[poi_pkg::DIV_W-2:0], 1'b0};
      end
      u <= u << 1;
      if (cnt == CNT_W'(poi_pkg::DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign q = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
endmodule

[design/planar_odometry_integrator.sv]
// Planar dead-reckoning odometry integrator, top level.
// Depends on poi_pkg, poi_if, poi_cordic, poi_mac, poi_div1000.
//
//   channel   dir   carries
//   in_ch     in    step_ms, vel_fwd, vel_side, yaw_rate
//   out_ch    out   pos_x, pos_y, heading_angle, quat_z, quat_w
//
// One item at a time. The time from accept to result valid is set by the
// bit-serial MAC walking multiplier bits and the divider producing one quotient bit
// a cycle; the next item is taken once the sequencer is back in idle.
// rst (synchronous) clears pose, sequencer and output valid.
// A new item is taken while the previous result waits on out_ch; a stalled
// out_ch only holds the sequencer in its final step.
module planar_odometry_integrator #(
  parameter int CORDIC_STEPS = 20,
  parameter int FRAC_BITS    = 16
) (
  input logic     clk,
  input logic     rst,
  poi_in_if.sink  in_ch,
  poi_out_if.source out_ch
);
  localparam int SH = FRAC_BITS + 8;  // heading scale shift
  localparam logic [poi_pkg::ACC_W-1:0] HEAD_HALF = poi_pkg::ACC_W'(1) << (SH - 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_COS0 = 4'd1;   // trig of old heading
  localparam logic [3:0] S_MX1  = 4'd2;   // vf*cos
  localparam logic [3:0] S_MX2  = 4'd3;   // - vs*sin
  localparam logic [3:0] S_MX3  = 4'd4;   // rx*step
  localparam logic [3:0] S_DX   = 4'd5;   // /1000
  localparam logic [3:0] S_MY1  = 4'd6;   // vf*sin
  localparam logic [3:0] S_MY2  = 4'd7;   // + vs*cos
  localparam logic [3:0] S_MY3  = 4'd8;
  localparam logic [3:0] S_DY   = 4'd9;
  localparam logic [3:0] S_MH1  = 4'd10;  // yaw*step
  localparam logic [3:0] S_MH2  = 4'd11;  // *K
  localparam logic [3:0] S_COS1 = 4'd12;  // trig of half new heading
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state;

  // latched item
  logic [15:0]        step;
  logic signed [31:0] vf, vs, wz;

  // pose
  logic signed [31:0] world_x, world_y;
  logic [31:0]        heading_acc;

  // output register
  logic               out_valid;
  logic signed [31:0] o_px, o_py;
  logic [31:0]        o_hd;
  logic [17:0]        o_qz, o_qw;

  // unit controls
  logic                             cord_start, cord_done;
  logic [31:0]                      cord_angle;
  logic signed [poi_pkg::TRIG_W-1:0] cord_cos, cord_sin;
  poi_pkg::mac_cmd_t                mac_cmd;
  logic signed [poi_pkg::ACC_W-1:0] mac_a, mac_acc;
  logic [31:0]                      mac_b;
  logic [poi_pkg::ACC_W-1:0]        mac_init;
  logic                             mac_done;
  logic                             div_start, div_done;
  logic signed [poi_pkg::DIV_W:0]   div_q;

  logic signed [poi_pkg::ACC_W-1:0] cos_ext, sin_ext;
  logic [31:0]                      head_next;

  assign cos_ext   = {{(poi_pkg::ACC_W-poi_pkg::TRIG_W){cord_cos[poi_pkg::TRIG_W-1]}}, cord_cos};
  assign sin_ext   = {{(poi_pkg::ACC_W-poi_pkg::TRIG_W){cord_sin[poi_pkg::TRIG_W-1]}}, cord_sin};
  // heading step is bits SH and up of p*K + half, modulo 2^32
  assign head_next = heading_acc + mac_acc[SH+31:SH];

  poi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .angle(cord_angle),
    .done(cord_done), .cos_o(cord_cos), .sin_o(cord_sin)
  );

  poi_mac u_mac (
    .clk(clk), .rst(rst), .cmd(mac_cmd), .a(mac_a), .b(mac_b), .init(mac_init),
    .done(mac_done), .acc(mac_acc)
  );

  poi_div1000 u_div (
    .clk(clk), .rst(rst), .start(div_start), .t(mac_acc), .done(div_done), .q(div_q)
  );

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] w,
                                                 input logic signed [poi_pkg::DIV_W:0] d);
    logic signed [poi_pkg::SUM_W-1:0] s;
    s = {{(poi_pkg::SUM_W-32){w[31]}}, w}
      + {{(poi_pkg::SUM_W-poi_pkg::DIV_W-1){d[poi_pkg::DIV_W]}}, d};
    if (s > poi_pkg::SAT_HI)      return 32'sh7FFFFFFF;
    else if (s < poi_pkg::SAT_LO) return 32'sh80000000;
    else                          return s[31:0];
  endfunction

  // Q2.30 -> Q1.16, round half up, clamp to +/-1.0
  function automatic logic [17:0] quat_of(input logic signed [poi_pkg::TRIG_W-1:0] v);
    logic signed [19:0] r;
    r = 20'((v + poi_pkg::TRIG_W'(8192)) >>> 14);
    if (r > poi_pkg::QUAT_HI)      return 18'(poi_pkg::QUAT_HI);
    else if (r < poi_pkg::QUAT_LO) return 18'(poi_pkg::QUAT_LO);
    else                           return r[17:0];
  endfunction

  always_ff @(posedge clk) begin
    mac_cmd.start <= 1'b0;
    cord_start    <= 1'b0;
    div_start     <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      world_x     <= '0;
      world_y     <= '0;
      heading_acc <= '0;
      out_valid   <= 1'b0;
      mac_cmd     <= '0;
    end else begin
      if (out_valid && out_ch.ready)
        out_valid <= 1'b0;
      unique case (state) inside
        S_IDLE: begin
          if (in_ch.valid) begin
            step       <= in_ch.step_ms;
            vf         <= in_ch.vel_fwd;
            vs         <= in_ch.vel_side;
            wz         <= in_ch.yaw_rate;
            cord_angle <= {heading_acc[30:0], 1'b0};  // old heading at 2*pi scale
            cord_start <= 1'b1;
            state      <= S_COS0;
          end
        end
        S_COS0: begin
          if (cord_done) begin
            mac_a    <= cos_ext;
            mac_b    <= vf;
            mac_init <= poi_pkg::ROT_HALF;  // rounding for the >>30
            mac_cmd  <= '{start: 1'b1, sub: 1'b0, sgn: 1'b1, nbits: 6'd32};
            state    <= S_MX1;
          end
        end
        S_MX1: begin
          if (mac_done) begin
            mac_a    <= sin_ext;
            mac_b    <= vs;
            mac_init <= mac_acc;
            mac_cmd  <= '{start: 1'b1, sub: 1'b1, sgn: 1'b1, nbits: 6'd32};
            state    <= S_MX2;
          end
        end
        S_MX2, S_MY2: begin
          if (mac_done) begin
            mac_a    <= mac_acc >>> poi_pkg::ROT_SHIFT;
            mac_b    <= {16'd0, step};
            mac_init <= poi_pkg::DIV_HALF;  // rounding for the /1000
            mac_cmd  <= '{start: 1'b1, sub: 1'b0, sgn: 1'b0, nbits: 6'd16};
            state    <= (state == S_MX2) ? S_MX3 : S_MY3;
          end
        end
        S_MX3, S_MY3: begin
          if (mac_done) begin
            div_start <= 1'b1;
            state     <= (state == S_MX3) ? S_DX : S_DY;
          end
        end
        S_DX: begin
          if (div_done) begin
            world_x  <= sat_add(world_x, div_q);
            mac_a    <= sin_ext;
            mac_b    <= vf;
            mac_init <= poi_pkg::ROT_HALF;
            mac_cmd  <= '{start: 1'b1, sub: 1'b0, sgn: 1'b1, nbits: 6'd32};
            state    <= S_MY1;
          end
        end
        S_MY1: begin
          if (mac_done) begin
            mac_a    <= cos_ext;
            mac_b    <= vs;
            mac_init <= mac_acc;
            mac_cmd  <= '{start: 1'b1, sub: 1'b0, sgn: 1'b1, nbits: 6'd32};
            state    <= S_MY2;
          end
        end
        S_DY: begin
          if (div_done) begin
            world_y  <= sat_add(world_y, div_q);
            mac_a    <= {{(poi_pkg::ACC_W-32){wz[31]}}, wz};
            mac_b    <= {16'd0, step};
            mac_init <= '0;
            mac_cmd  <= '{start: 1'b1, sub: 1'b0, sgn: 1'b0, nbits: 6'd16};
            state    <= S_MH1;
          end
        end
        S_MH1: begin
          if (mac_done) begin
            // only the low SH+32 bits of p*K matter, so p need not be trimmed
            mac_a    <= mac_acc;
            mac_b    <= poi_pkg::ANG_K;
            mac_init <= HEAD_HALF;
            mac_cmd  <= '{start: 1'b1, sub: 1'b0, sgn: 1'b0,
                          nbits: 6'(poi_pkg::ANG_K_BITS)};
            state    <= S_MH2;
          end
        end
        S_MH2: begin
          if (mac_done) begin
            heading_acc <= head_next;
            cord_angle  <= head_next;  // half heading at 2*pi scale
            cord_start  <= 1'b1;
            state       <= S_COS1;
          end
        end
        S_COS1: begin
          if (cord_done)
            state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            o_px      <= world_x;
            o_py      <= world_y;
            o_hd      <= heading_acc;
            o_qz      <= quat_of(cord_sin);
            o_qw      <= quat_of(cord_cos);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.pos_x         = o_px;
  assign out_ch.pos_y         = o_py;
  assign out_ch.heading_angle = o_hd;
  assign out_ch.quat_z        = o_qz;
  assign out_ch.quat_w        = o_qw;
endmodule

[design/poi_checker.sv]
// Port-level checks for the odometry integrator, bound to the top level.
// Depends on planar_odometry_integrator_macros.svh and the top level.
`include "planar_odometry_integrator_macros.svh"

module poi_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pos_x,
  input logic signed [17:0] quat_z,
  input logic signed [17:0] quat_w
);
  // one item in flight: intake closes after each accept
  `POI_ASSERT(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready, "item accepted while busy")
  `POI_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(pos_x)), "result dropped or changed while stalled")
  `POI_ASSERT(a_quat_range, clk, rst, out_valid |-> (quat_z >= -18'sd65536 && quat_z <= 18'sd65536 && quat_w >= -18'sd65536 && quat_w <= 18'sd65536), "quaternion out of range")
  `POI_ASSERT_ALWAYS(a_reset, clk, rst |=> (!out_valid && in_ready), "reset left block busy")
endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .pos_x(out_ch.pos_x), .quat_z(out_ch.quat_z), .quat_w(out_ch.quat_w)
);

[test/tb.sv]
// Testbench for planar_odometry_integrator: directed and random odometry steps,
// each result checked against a predicted pose. Depends on poi_if and the top level.
module tb;

  localparam int NUM_RANDOM = 1350;
  localparam int TRIG_ITERS = 20;      // matches CORDIC_STEPS default
  localparam int FRAC = 16;            // matches FRAC_BITS default
  localparam longint HEAD_K = 87496355;
  localparam longint CYCLE_LIMIT = 3000000;

  // arctan(2^-i), binary angle of full scale 2*pi
  localparam bit [31:0] ARCTAN_BA [0:TRIG_ITERS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518};

  typedef struct {
    bit [15:0]        step;
    bit signed [31:0] fwd;
    bit signed [31:0] side;
    bit signed [31:0] yaw;
  } odo_step_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        heading;
    logic signed [17:0] qz;
    logic signed [17:0] qw;
  } pose_t;

  class pose_scoreboard;
    longint           world_x, world_y;
    bit [31:0]        heading;
    pose_t            pose_q[$];
    int unsigned      errors;

    function new();
      world_x = 0;
      world_y = 0;
      heading = 0;
      errors  = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // rounds half up: v / 2^s
    function longint round_shift(longint v, int s);
      return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function longint round_div1000(longint v);
      longint t;
      t = v + 500;
      if (t >= 0) return t / 1000;
      return -((-t + 999) / 1000);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // cos, sin in Q2.30 of angle (2^32 = 2*pi)
    function void rotate_vec(bit [31:0] ang, output longint c, output longint s);
      bit     flip;
      longint vx, vy, z, dx, dy;
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang - 32'h80000000;
      vx = 652032874;
      vy = 0;
      z  = longint'($signed(ang));
      for (int i = 0; i < TRIG_ITERS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (z >= 0) begin
          vx -= dx; vy += dy; z -= longint'(ARCTAN_BA[i]);
        end else begin
          vx += dx; vy -= dy; z += longint'(ARCTAN_BA[i]);
        end
      end
      c = flip ? -vx : vx;
      s = flip ? -vy : vy;
    endfunction

    function logic signed [17:0] quat_of(longint v);
      longint q;
      q = round_shift(v, 14);
      if (q > 65536) q = 65536;
      if (q < -65536) q = -65536;
      return q[17:0];
    endfunction

    function void note_step(odo_step_t it);
      longint    c, s, rx, ry, st, vf, vs, p, ph;
      bit [63:0] pl, low;
      bit [31:0] dh;
      pose_t     e;
      st = it.step;
      vf = it.fwd;
      vs = it.side;
      rotate_vec({heading[30:0], 1'b0}, c, s);   // old heading = half angle doubled
      rx = round_shift(vf * c - vs * s, 30);
      ry = round_shift(vf * s + vs * c, 30);
      world_x = clamp32(world_x + round_div1000(rx * st));
      world_y = clamp32(world_y + round_div1000(ry * st));
      // heading delta split so the low part is rounded once
      p   = longint'(it.yaw) * st;
      pl  = p & ((64'd1 << (FRAC + 8)) - 1);
      ph  = (p - longint'(pl)) >>> (FRAC + 8);
      low = (pl * HEAD_K + (64'd1 << (FRAC + 7))) >> (FRAC + 8);
      dh  = 32'(ph * HEAD_K + longint'(low));
      heading += dh;
      rotate_vec(heading, c, s);
      e.x = world_x[31:0];
      e.y = world_y[31:0];
      e.heading = heading;
      e.qz = quat_of(s);
      e.qw = quat_of(c);
      pose_q.push_back(e);
    endfunction

    task check_pose(pose_t got);
      pose_t e;
      if (pose_q.size() == 0) begin
        report("result with no step pending");
        return;
      end
      e = pose_q.pop_front();
      if (got.x !== e.x) report($sformatf("pos_x %0d exp %0d", got.x, e.x));
      if (got.y !== e.y) report($sformatf("pos_y %0d exp %0d", got.y, e.y));
      if (got.heading !== e.heading)
        report($sformatf("heading %h exp %h", got.heading, e.heading));
      if (got.qz !== e.qz) report($sformatf("quat_z %0d exp %0d", got.qz, e.qz));
      if (got.qw !== e.qw) report($sformatf("quat_w %0d exp %0d", got.qw, e.qw));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm;          // no idling on either side while set
  longint cycles = 0;

  poi_in_if  in_ch();
  poi_out_if out_ch();

  planar_odometry_integrator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pose_scoreboard poses = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function int idle_len();
    if (calm) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  // receiving side: check each accepted result, stall at random
  int stall_left = 0;
  always @(posedge clk) begin
    pose_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.pos_x;
      got.y = out_ch.pos_y;
      got.heading = out_ch.heading_angle;
      got.qz = out_ch.quat_z;
      got.qw = out_ch.quat_w;
      poses.check_pose(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  function odo_step_t mk(bit [15:0] st, bit [31:0] f, bit [31:0] s, bit [31:0] y);
    odo_step_t it;
    it.step = st; it.fwd = f; it.side = s; it.yaw = y;
    return it;
  endfunction

  // typical motion keeps the pose off the rails; the rest covers full ranges
  function odo_step_t random_step();
    odo_step_t it;
    case ($urandom_range(0, 9)) inside
      [0:5]: begin
        it.step = 16'($urandom_range(0, 200));
        it.fwd  = $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
        it.side = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        it.yaw  = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
      end
      [6:7]: begin
        it.step = 16'($urandom()); it.fwd = $urandom();
        it.side = $urandom(); it.yaw = $urandom();
      end
      8: begin
        it.step = 16'($urandom_range(0, 20)); it.fwd = $urandom();
        it.side = $urandom(); it.yaw = $urandom();
      end
      default: begin
        it.step = 0; it.fwd = $urandom();
        it.side = $urandom(); it.yaw = $urandom();
      end
    endcase
    return it;
  endfunction

  // holds valid high across back-to-back items; only lowers it for a real gap
  task automatic send_step(odo_step_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.step_ms  <= it.step;
    in_ch.vel_fwd  <= it.fwd;
    in_ch.vel_side <= it.side;
    in_ch.yaw_rate <= it.yaw;
    do @(posedge clk); while (!in_ch.ready);
    poses.note_step(it);
  endtask

  initial begin
    odo_step_t dir_q[$];
    rst <= 1'b1;
    calm = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.step_ms <= '0;
    in_ch.vel_fwd <= '0;
    in_ch.vel_side <= '0;
    in_ch.yaw_rate <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero step, small moves, each quadrant of heading, saturation, heading wrap
    dir_q.push_back(mk(16'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    dir_q.push_back(mk(16'd1, 32'h00010000, 32'h00000000, 32'h00000000));
    dir_q.push_back(mk(16'd1000, 32'h00010000, 32'h00010000, 32'h00010000));
    dir_q.push_back(mk(16'd1000, 32'h00010000, 32'hFFFF0000, 32'h00020000));
    dir_q.push_back(mk(16'd1000, 32'h00020000, 32'h00000000, 32'h00020000));
    dir_q.push_back(mk(16'd1000, 32'h00020000, 32'h00010000, 32'h00020000));
    dir_q.push_back(mk(16'd1000, 32'hFFFE0000, 32'h00000000, 32'hFFFC0000));
    dir_q.push_back(mk(16'd65535, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000));
    dir_q.push_back(mk(16'd65535, 32'h7FFFFFFF, 32'h80000000, 32'h00000000));
    dir_q.push_back(mk(16'd65535, 32'h80000000, 32'h80000000, 32'h00000000));
    dir_q.push_back(mk(16'd65535, 32'h80000000, 32'h7FFFFFFF, 32'h00000000));
    dir_q.push_back(mk(16'd65535, 32'h00000000, 32'h00000000, 32'h7FFFFFFF));
    dir_q.push_back(mk(16'd65535, 32'h00000000, 32'h00000000, 32'h80000000));
    dir_q.push_back(mk(16'd65535, 32'h80000000, 32'h80000000, 32'h80000000));
    dir_q.push_back(mk(16'd65535, 32'h00000000, 32'h00000000, 32'hFFFFFFFF));
    dir_q.push_back(mk(16'd1, 32'h00000001, 32'hFFFFFFFF, 32'h00000001));
    dir_q.push_back(mk(16'd0, 32'h00000000, 32'h00000000, 32'h00000000));
    dir_q.push_back(mk(16'd65535, 32'hFFFFFFFF, 32'h00000001, 32'h55555555));
    dir_q.push_back(mk(16'hAAAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
    dir_q.push_back(mk(16'h5555, 32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    foreach (dir_q[i]) send_step(dir_q[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      send_step(random_step());
    end
    in_ch.valid <= 1'b0;
    calm = 1'b1;

    while (poses.pose_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (poses.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/poi_pkg.sv
design/poi_if.sv
design/poi_cordic.sv
design/poi_mac.sv
design/poi_div1000.sv
design/planar_odometry_integrator.sv
design/poi_checker.sv
test/tb.sv
